@@ rtl/spirv_image_format_patcher_core_assert.svh @@
// Assertion helpers for the image format patcher.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SPIRV_IMAGE_FORMAT_PATCHER_CORE_ASSERT_SVH
`define SPIRV_IMAGE_FORMAT_PATCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SIFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sifp_pkg.sv @@
package sifp_pkg;

    localparam int HEADER_WORDS_DEF = 5;

    localparam logic [15:0] OP_CAPABILITY       = 16'd17;
    localparam logic [15:0] OP_TYPE_IMAGE       = 16'd25;
    localparam logic [31:0] CAP_WRITE_NO_FORMAT = 32'd56;
    localparam logic [31:0] CAP_SHADER          = 32'd1;
    localparam logic [31:0] SAMPLED_NO_SAMPLER  = 32'd2;
    localparam logic [31:0] FMT_RGBA16F         = 32'd2;
    localparam logic [31:0] FMT_RGBA8           = 32'd4;

    // Operand positions inside an instruction, start word at 0
    localparam logic [15:0] POS_CAP_OPERAND = 16'd1;
    localparam logic [15:0] POS_IMG_SAMPLED = 16'd7;
    localparam logic [15:0] POS_IMG_FORMAT  = 16'd8;

    localparam logic [15:0] MIN_LEN_CAP = 16'd2;
    localparam logic [15:0] MIN_LEN_IMG = 16'd9;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        patched;
    } result_t;

endpackage

@@ rtl/spirv_image_format_patcher_core.sv @@
// SPIR-V image format patcher.
// Input channel: word_in/last_in with in_valid/in_ready; one beat is one
// 32-bit module word, last_in marks the final word of a module.
// Output channel: word_out/last_out/was_patched with out_valid/out_ready;
// exactly one output beat per input beat, in order.
// Config: cfg_wr_en/cfg_wr_data write hdr_mode; write only while no
// beats are in flight.
// Accepted words go to the output register, or to skid if it is held.
// Throughput: one word per cycle while the skid register is empty; the
// per-word work is a position counter increment and a few compares
// between the state registers and the output register.
// Stall: a skid register holds one extra beat while out_ready is low;
// in_ready drops only when that skid beat is occupied.
// Reset: clears framing state, hdr_mode and both valid flags; the first
// HEADER_WORDS words after reset or after a last beat pass as header.
module spirv_image_format_patcher_core #(
    parameter int HEADER_WORDS = sifp_pkg::HEADER_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word_in,
    input  logic        last_in,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] word_out,
    output logic        last_out,
    output logic        was_patched
);

`include "spirv_image_format_patcher_core_assert.svh"

    localparam int HdrW = $clog2(HEADER_WORDS + 1);
    localparam logic [HdrW-1:0] HdrCount = HdrW'(HEADER_WORDS);

    // Framing state
    logic [HdrW-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]     pos_reg, pos_next;
    logic [15:0]     len_reg, len_next;
    logic            cap_reg, cap_next;   // capability instr, long enough
    logic            img_reg, img_next;   // image type instr, long enough
    logic            two_reg, two_next;   // sampled operand was 2
    logic            hdr_mode_reg;

    // Output side: result register plus one skid beat
    sifp_pkg::result_t out_data_reg, skid_data_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic        accept;
    logic        out_fire;
    logic [15:0] wc;
    logic [15:0] len_new;
    logic [16:0] pos_inc;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign wc      = word_in[31:16];
    assign len_new = (wc == 16'd0) ? 16'd1 : wc;
    assign pos_inc = {1'b0, pos_reg} + 17'd1;

    // Per-word rewrite and framing update
    always_comb
    begin
        res          = '{word: word_in, last: last_in, patched: 1'b0};
        hdr_cnt_next = hdr_cnt_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        cap_next     = cap_reg;
        img_next     = img_reg;
        two_next     = two_reg;

        priority if (hdr_cnt_reg < HdrCount)
        begin
            // header word: count it and pass it
            hdr_cnt_next = hdr_cnt_reg + HdrW'(1);
        end
        else if (pos_reg == 16'd0)
        begin
            // instruction start word: latch length and opcode class
            len_next = len_new;
            cap_next = (word_in[15:0] == sifp_pkg::OP_CAPABILITY)
                       && (len_new >= sifp_pkg::MIN_LEN_CAP);
            img_next = (word_in[15:0] == sifp_pkg::OP_TYPE_IMAGE)
                       && (len_new >= sifp_pkg::MIN_LEN_IMG);
            two_next = 1'b0;
            pos_next = (len_new > 16'd1) ? 16'd1 : 16'd0;
        end
        else
        begin
            if (cap_reg && pos_reg == sifp_pkg::POS_CAP_OPERAND
                && word_in == sifp_pkg::CAP_WRITE_NO_FORMAT)
            begin
                res.word    = sifp_pkg::CAP_SHADER;
                res.patched = 1'b1;
            end
            if (img_reg)
            begin
                if (pos_reg == sifp_pkg::POS_IMG_SAMPLED)
                begin
                    two_next = (word_in == sifp_pkg::SAMPLED_NO_SAMPLER);
                end
                else if (pos_reg == sifp_pkg::POS_IMG_FORMAT && two_reg)
                begin
                    res.word    = hdr_mode_reg ? sifp_pkg::FMT_RGBA16F
                                               : sifp_pkg::FMT_RGBA8;
                    res.patched = 1'b1;
                end
            end
            // advance, wrap to start at the end of the instruction
            pos_next = (pos_inc >= {1'b0, len_reg}) ? 16'd0 : pos_inc[15:0];
        end

        // end of module: drop any partial instruction, restart framing
        if (last_in)
        begin
            hdr_cnt_next = '0;
            pos_next     = 16'd0;
            len_next     = 16'd0;
            cap_next     = 1'b0;
            img_next     = 1'b0;
            two_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg  <= '0;
            pos_reg      <= 16'd0;
            len_reg      <= 16'd0;
            cap_reg      <= 1'b0;
            img_reg      <= 1'b0;
            two_reg      <= 1'b0;
            hdr_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hdr_mode_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                hdr_cnt_reg <= hdr_cnt_next;
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                cap_reg     <= cap_next;
                img_reg     <= img_next;
                two_reg     <= two_next;
            end
        end
    end

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            // output slot frees: refill from skid first, else from input
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            // output held: park the new beat in skid
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (accept)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_out    = out_data_reg.word;
    assign last_out    = out_data_reg.last;
    assign was_patched = out_data_reg.patched;

    `SIFP_ASSERT_NOW(a_skid_implies_out, skid_valid_reg, out_valid_reg,
        "skid beat held without an output beat")
    `SIFP_ASSERT_NOW(a_pos_in_range, pos_reg != 16'd0, pos_reg < len_reg,
        "instruction position beyond its length")
    `SIFP_ASSERT_NOW(a_hdr_cnt_sat, 1'b1, hdr_cnt_reg <= HdrCount,
        "header counter past header size")
    `SIFP_ASSERT_NEXT(a_last_clears, accept && last_in,
        hdr_cnt_reg == '0 && pos_reg == 16'd0 && !two_reg,
        "framing not cleared after last beat")
    `SIFP_ASSERT_NOW(a_patch_value, out_valid_reg && out_data_reg.patched,
        out_data_reg.word == sifp_pkg::CAP_SHADER
        || out_data_reg.word == sifp_pkg::FMT_RGBA16F
        || out_data_reg.word == sifp_pkg::FMT_RGBA8,
        "patched word holds an unexpected value")

endmodule
